### hdl/mf3_pkg.sv
// Shared constants and types for the 3x3 median filter.
`timescale 1ns / 1ps

package mf3_pkg;

    // Default parameter values
    localparam int MAX_COLS_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Fixed widths of the configuration registers and counters
    localparam int ROW_BITS       = 12;
    localparam int COL_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    // Result queue depth (power of two)
    localparam int FIFO_DEPTH     = 8;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_COUNT = 2'd0,
        CFG_COL_COUNT = 2'd1
    } mf3_cfg_index_t;

    // Per-item control that travels down the pipeline
    typedef struct packed {
        logic valid;       // item does work
        logic drain;       // last-row drain item
        logic load;        // window reload (first column)
        logic upper_sel;   // top row comes from the upper line
        logic emit_main;   // emits the median of the window
        logic emit_edge;   // emits the right edge column
        logic last_frame;  // main result closes the frame
    } mf3_ctrl_t;

endpackage

### hdl/median_3x3_image_filter.sv
// Top level of the streaming 3x3 median filter with replicated border.
// Throughput: one item per cycle while s_ready is high; the last pixel of a row after
//   the first can give two results, which leave at one per cycle while m_ready is
//   high, through an 8-entry result queue that gates s_ready.
// Reset: synchronous, active low; clears counters and config (1 row, 1 column).
//   Line buffers are not cleared; unwritten entries may be read but never reach a result.
`timescale 1ns / 1ps

module median_3x3_image_filter #(
    parameter int MAX_COLS   = mf3_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [PIXEL_BITS-1:0]               s_pixel_value,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [PIXEL_BITS-1:0]               m_filtered_value,
    output logic [PIXEL_BITS-1:0]               m_running_min,
    output logic [PIXEL_BITS-1:0]               m_running_max,
    output logic                                m_last_of_item,
    output logic                                m_last_of_frame
);

    localparam int AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int P   = PIXEL_BITS;
    localparam int RW  = 3 * P + 2;
    localparam int FCW = $clog2(mf3_pkg::FIFO_DEPTH) + 1;
    localparam int SW  = FCW + 1;

    mf3_pkg::mf3_ctrl_t ctrl_a, ctrl_c;
    logic [AW-1:0]      raddr_a, raddr_b;
    logic [P-1:0]       pixel_a;
    logic               cfg_restart, s_accept;
    logic [3*P-1:0]     win0, win1, win2;
    logic [2:0]         pend_win;
    logic [1:0]         pend_med;
    logic               push0, push1;
    logic [RW-1:0]      res0, res1, head;
    logic [FCW-1:0]     fifo_count;
    logic [SW-1:0]      credit_sum;

    // Config writes are taken at once
    assign cfg_ready = 1'b1;

    // Accept only with room for everything in flight plus two more results
    assign credit_sum = SW'(fifo_count) + SW'(pend_win) + SW'(pend_med) + SW'(2);
    assign s_ready    = (credit_sum <= SW'(mf3_pkg::FIFO_DEPTH));
    assign s_accept   = s_valid && s_ready;

    mf3_ctrl #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS),
        .AW         (AW)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_fire      (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_accept      (s_accept),
        .s_req_type    (s_req_type),
        .s_pixel_value (s_pixel_value),
        .ctrl_a        (ctrl_a),
        .raddr_a       (raddr_a),
        .raddr_b       (raddr_b),
        .pixel_a       (pixel_a),
        .cfg_restart   (cfg_restart)
    );

    mf3_window #(
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS),
        .AW         (AW)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_a  (ctrl_a),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .pixel_a (pixel_a),
        .ctrl_c  (ctrl_c),
        .win0    (win0),
        .win1    (win1),
        .win2    (win2),
        .pend    (pend_win)
    );

    mf3_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl_c      (ctrl_c),
        .win0        (win0),
        .win1        (win1),
        .win2        (win2),
        .cfg_restart (cfg_restart),
        .push0       (push0),
        .push1       (push1),
        .res0        (res0),
        .res1        (res1),
        .pend        (pend_med)
    );

    mf3_fifo #(
        .WIDTH (RW),
        .DEPTH (mf3_pkg::FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (push0),
        .push1     (push1),
        .data0     (res0),
        .data1     (res1),
        .pop       (m_valid && m_ready),
        .out_valid (m_valid),
        .out_data  (head),
        .count     (fifo_count)
    );

    // Unpack the queue head
    assign m_filtered_value = head[3*P+1:2*P+2];
    assign m_running_min    = head[2*P+1:P+2];
    assign m_running_max    = head[P+1:2];
    assign m_last_of_item   = head[1];
    assign m_last_of_frame  = head[0];

`ifndef SYNTHESIS
    // Queue plus in-flight results never exceed the queue depth
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        (SW'(fifo_count) + SW'(pend_win) + SW'(pend_med)) <= SW'(mf3_pkg::FIFO_DEPTH))
        else $error("result credit exceeded");

    // The bottom-right result ends its item
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_frame) |-> m_last_of_item)
        else $error("last_of_frame without last_of_item");

    // Running extremes bracket the value they include
    a_extremes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_running_min <= m_filtered_value)
                     && (m_filtered_value <= m_running_max)))
        else $error("running min/max do not bracket the result");
`endif

endmodule

### hdl/mf3_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write, and read with old data on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### hdl/mf3_ctrl.sv
// Frame position counters, configuration registers and line buffer addressing.
`timescale 1ns / 1ps

module mf3_ctrl #(
    parameter int MAX_COLS   = mf3_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF,
    parameter int AW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_fire,
    input  logic [mf3_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                s_accept,
    input  logic                                s_req_type,
    input  logic [PIXEL_BITS-1:0]               s_pixel_value,
    output mf3_pkg::mf3_ctrl_t                  ctrl_a,
    output logic [AW-1:0]                       raddr_a,
    output logic [AW-1:0]                       raddr_b,
    output logic [PIXEL_BITS-1:0]               pixel_a,
    output logic                                cfg_restart
);

    localparam int RB = mf3_pkg::ROW_BITS;
    localparam int CB = mf3_pkg::COL_BITS;

    logic [RB-1:0] row_count_reg, row_count_next;
    logic [CB-1:0] col_count_reg, col_count_next;
    logic [RB-1:0] in_row_reg, in_row_next;
    logic [CB-1:0] in_col_reg, in_col_next;
    logic [CB-1:0] drain_col_reg, drain_col_next;

    logic [RB-1:0] rows_eff;
    logic [CB-1:0] cols_eff;
    logic [CB-1:0] col_d, col_r, col_rd_a;
    logic          pix_ok, drain_ok, last_col, d_last, has_row;
    logic          cfg_row_wr, cfg_col_wr;

    // Effective frame size
    always_comb begin
        rows_eff = (row_count_reg == '0) ? RB'(1) : row_count_reg;
        priority if (col_count_reg == '0) begin
            cols_eff = CB'(1);
        end else if (int'(col_count_reg) > MAX_COLS) begin
            cols_eff = CB'(MAX_COLS);
        end else begin
            cols_eff = col_count_reg;
        end
    end

    // Position decode for pixel and drain items
    always_comb begin
        pix_ok   = (in_row_reg < rows_eff) && (in_col_reg < cols_eff);
        drain_ok = (in_row_reg >= rows_eff);
        last_col = (in_col_reg == cols_eff - CB'(1));
        has_row  = (in_row_reg != '0);
        col_d    = (drain_col_reg >= cols_eff) ? cols_eff - CB'(1) : drain_col_reg;
        d_last   = (col_d == cols_eff - CB'(1));
        col_r    = d_last ? col_d : col_d + CB'(1);
        col_rd_a = !s_req_type ? in_col_reg : ((col_d == '0) ? '0 : col_r);
    end

    // Line buffer read addresses; port B serves the second column of a drain reload
    assign raddr_a = AW'(col_rd_a);
    assign raddr_b = (cols_eff >= CB'(2)) ? AW'(1) : '0;
    assign pixel_a = s_pixel_value;

    // Control for the item entering the pipeline
    always_comb begin
        ctrl_a            = '0;
        ctrl_a.valid      = s_accept && (s_req_type ? drain_ok : pix_ok);
        ctrl_a.drain      = s_req_type;
        ctrl_a.load       = s_req_type ? (col_d == '0) : (in_col_reg == '0);
        ctrl_a.upper_sel  = s_req_type ? (rows_eff >= RB'(2)) : (in_row_reg >= RB'(2));
        ctrl_a.emit_main  = ctrl_a.valid && (s_req_type || (has_row && in_col_reg != '0));
        ctrl_a.emit_edge  = ctrl_a.valid && !s_req_type && has_row && last_col;
        ctrl_a.last_frame = ctrl_a.valid && s_req_type && d_last;
    end

    assign cfg_row_wr  = cfg_fire && (cfg_index == mf3_pkg::CFG_ROW_COUNT);
    assign cfg_col_wr  = cfg_fire && (cfg_index == mf3_pkg::CFG_COL_COUNT);
    assign cfg_restart = cfg_row_wr || cfg_col_wr;

    // Counter and register update
    always_comb begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        drain_col_next = drain_col_reg;
        priority if (cfg_restart) begin
            if (cfg_row_wr) begin
                row_count_next = cfg_data[RB-1:0];
            end else begin
                col_count_next = cfg_data[CB-1:0];
            end
            in_row_next    = '0;
            in_col_next    = '0;
            drain_col_next = '0;
        end else if (ctrl_a.valid && !s_req_type) begin
            if (last_col) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RB'(1);
            end else begin
                in_col_next = in_col_reg + CB'(1);
            end
        end else if (ctrl_a.valid) begin
            if (d_last) begin
                in_row_next    = '0;
                in_col_next    = '0;
                drain_col_next = '0;
            end else begin
                drain_col_next = col_d + CB'(1);
            end
        end else begin
            drain_col_next = drain_col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= RB'(1);
            col_count_reg <= CB'(1);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            drain_col_reg <= '0;
        end else begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            drain_col_reg <= drain_col_next;
        end
    end

endmodule

### hdl/mf3_window.sv
// Line buffer read-modify-write with forwarding, column sort and 3x3 window.
`timescale 1ns / 1ps

module mf3_window #(
    parameter int MAX_COLS   = mf3_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF,
    parameter int AW         = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mf3_pkg::mf3_ctrl_t        ctrl_a,
    input  logic [AW-1:0]             raddr_a,
    input  logic [AW-1:0]             raddr_b,
    input  logic [PIXEL_BITS-1:0]     pixel_a,
    output mf3_pkg::mf3_ctrl_t        ctrl_c,
    output logic [3*PIXEL_BITS-1:0]   win0,
    output logic [3*PIXEL_BITS-1:0]   win1,
    output logic [3*PIXEL_BITS-1:0]   win2,
    output logic [2:0]                pend
);

    localparam int P = PIXEL_BITS;

    // Sorted column packed as {high, middle, low}
    function automatic logic [3*P-1:0] sort3(input logic [P-1:0] a,
                                              input logic [P-1:0] b,
                                              input logic [P-1:0] c);
        logic [P-1:0] lo1, hi1, hi, m, lo, md;
        lo1 = (a < b) ? a : b;
        hi1 = (a < b) ? b : a;
        hi  = (hi1 > c) ? hi1 : c;
        m   = (hi1 > c) ? c : hi1;
        lo  = (lo1 < m) ? lo1 : m;
        md  = (lo1 < m) ? m : lo1;
        return {hi, md, lo};
    endfunction

    mf3_pkg::mf3_ctrl_t ctrl_b_reg, ctrl_c_reg;
    logic [P-1:0]       pix_b_reg;
    logic [AW-1:0]      waddr_b_reg;
    logic               fwd_hit_a_reg, fwd_hit_b_reg;
    logic [2*P-1:0]     fwd_data_reg;

    logic [2*P-1:0]     rdata_a, rdata_b, ent_a, ent_b, wdata_b;
    logic               we_b;
    logic [P-1:0]       top_a, bot_a, top_b;
    logic [3*P-1:0]     col_a_sorted, col_b_sorted;
    logic [3*P-1:0]     win_reg  [3];
    logic [3*P-1:0]     win_next [3];

    // Line buffer entry is {upper row, middle row} of one column
    mf3_ram #(
        .WIDTH (2*P),
        .DEPTH (MAX_COLS),
        .AW    (AW)
    ) u_line_ram (
        .aclk    (aclk),
        .we      (we_b),
        .waddr   (waddr_b_reg),
        .wdata   (wdata_b),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Forward the write that lands on the same edge as the read
    assign ent_a = fwd_hit_a_reg ? fwd_data_reg : rdata_a;
    assign ent_b = fwd_hit_b_reg ? fwd_data_reg : rdata_b;

    // Build the new columns; pixels shift middle to upper and store the pixel
    always_comb begin
        top_a        = ctrl_b_reg.upper_sel ? ent_a[2*P-1:P] : ent_a[P-1:0];
        bot_a        = ctrl_b_reg.drain ? ent_a[P-1:0] : pix_b_reg;
        top_b        = ctrl_b_reg.upper_sel ? ent_b[2*P-1:P] : ent_b[P-1:0];
        col_a_sorted = sort3(top_a, ent_a[P-1:0], bot_a);
        col_b_sorted = sort3(top_b, ent_b[P-1:0], ent_b[P-1:0]);
        we_b         = ctrl_b_reg.valid && !ctrl_b_reg.drain;
        wdata_b      = {ent_a[P-1:0], pix_b_reg};
    end

    // Window shift or reload
    always_comb begin
        win_next = win_reg;
        if (ctrl_b_reg.valid) begin
            if (ctrl_b_reg.load) begin
                win_next[0] = col_a_sorted;
                win_next[1] = col_a_sorted;
                win_next[2] = ctrl_b_reg.drain ? col_b_sorted : col_a_sorted;
            end else begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = col_a_sorted;
            end
        end
    end

    // Pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_b_reg    <= '0;
            ctrl_c_reg    <= '0;
            fwd_hit_a_reg <= 1'b0;
            fwd_hit_b_reg <= 1'b0;
        end else begin
            ctrl_b_reg    <= ctrl_a;
            ctrl_c_reg    <= ctrl_b_reg;
            fwd_hit_a_reg <= we_b && (waddr_b_reg == raddr_a);
            fwd_hit_b_reg <= we_b && (waddr_b_reg == raddr_b);
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        pix_b_reg    <= pixel_a;
        waddr_b_reg  <= raddr_a;
        fwd_data_reg <= wdata_b;
        win_reg      <= win_next;
    end

    assign ctrl_c = ctrl_c_reg;
    assign win0   = win_reg[0];
    assign win1   = win_reg[1];
    assign win2   = win_reg[2];
    assign pend   = 3'(ctrl_b_reg.emit_main) + 3'(ctrl_b_reg.emit_edge)
                  + 3'(ctrl_c_reg.emit_main) + 3'(ctrl_c_reg.emit_edge);

endmodule

### hdl/mf3_median.sv
// Median selection over sorted columns and running min/max of the results.
`timescale 1ns / 1ps

module mf3_median #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mf3_pkg::mf3_ctrl_t        ctrl_c,
    input  logic [3*PIXEL_BITS-1:0]   win0,
    input  logic [3*PIXEL_BITS-1:0]   win1,
    input  logic [3*PIXEL_BITS-1:0]   win2,
    input  logic                      cfg_restart,
    output logic                      push0,
    output logic                      push1,
    output logic [3*PIXEL_BITS+1:0]   res0,
    output logic [3*PIXEL_BITS+1:0]   res1,
    output logic [1:0]                pend
);

    localparam int P = PIXEL_BITS;

    function automatic logic [P-1:0] min2(input logic [P-1:0] a, input logic [P-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [P-1:0] max2(input logic [P-1:0] a, input logic [P-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [P-1:0] med3(input logic [P-1:0] a,
                                          input logic [P-1:0] b,
                                          input logic [P-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    mf3_pkg::mf3_ctrl_t ctrl_d_reg;
    logic [P-1:0] lo0_reg, md0_reg, hi0_reg, lo1_reg, md1_reg, hi1_reg;
    logic [P-1:0] min_reg, min_next, max_reg, max_next;
    logic [P-1:0] v0, v1, mn0, mx0, mn1, mx1;

    // Stage C: max of lows, median of middles, min of highs
    always_ff @(posedge aclk) begin
        lo0_reg <= max2(max2(win0[P-1:0], win1[P-1:0]), win2[P-1:0]);
        md0_reg <= med3(win0[2*P-1:P], win1[2*P-1:P], win2[2*P-1:P]);
        hi0_reg <= min2(min2(win0[3*P-1:2*P], win1[3*P-1:2*P]), win2[3*P-1:2*P]);
        // right edge: last column replicated
        lo1_reg <= max2(win1[P-1:0], win2[P-1:0]);
        md1_reg <= med3(win1[2*P-1:P], win2[2*P-1:P], win2[2*P-1:P]);
        hi1_reg <= min2(win1[3*P-1:2*P], win2[3*P-1:2*P]);
    end

    // Stage D: final median and running extremes, in result order
    always_comb begin
        v0  = med3(lo0_reg, md0_reg, hi0_reg);
        v1  = med3(lo1_reg, md1_reg, hi1_reg);
        mn0 = ctrl_d_reg.emit_main ? min2(min_reg, v0) : min_reg;
        mx0 = ctrl_d_reg.emit_main ? max2(max_reg, v0) : max_reg;
        mn1 = min2(mn0, v1);
        mx1 = max2(mx0, v1);
    end

    // Frame restart on a config write or after the bottom-right result
    always_comb begin
        priority if (cfg_restart || (ctrl_d_reg.emit_main && ctrl_d_reg.last_frame)) begin
            min_next = '1;
            max_next = '0;
        end else if (ctrl_d_reg.emit_edge) begin
            min_next = mn1;
            max_next = mx1;
        end else begin
            min_next = mn0;
            max_next = mx0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_d_reg <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
        end else begin
            ctrl_d_reg <= ctrl_c;
            min_reg    <= min_next;
            max_reg    <= max_next;
        end
    end

    // Result entries: {value, min, max, last_of_item, last_of_frame}
    assign push0 = ctrl_d_reg.emit_main;
    assign push1 = ctrl_d_reg.emit_edge;
    assign res0  = {v0, mn0, mx0, !ctrl_d_reg.emit_edge, ctrl_d_reg.last_frame};
    assign res1  = {v1, mn1, mx1, 1'b1, 1'b0};
    assign pend  = 2'(ctrl_d_reg.emit_main) + 2'(ctrl_d_reg.emit_edge);

endmodule

### hdl/mf3_fifo.sv
// Result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps

module mf3_fifo #(
    parameter int WIDTH = 26,
    parameter int DEPTH = mf3_pkg::FIFO_DEPTH,
    parameter int PW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH) + 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push0,
    input  logic             push1,
    input  logic [WIDTH-1:0] data0,
    input  logic [WIDTH-1:0] data1,
    input  logic             pop,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    n_push;

    assign n_push = CW'(push0) + CW'(push1);

    always_comb begin
        wptr_next  = wptr_reg + PW'(n_push);
        rptr_next  = rptr_reg + PW'(pop);
        count_next = count_reg + n_push - CW'(pop);
    end

    // Storage; a lone edge result takes the first free slot
    always_ff @(posedge aclk) begin
        if (push0 || push1) begin
            mem_reg[wptr_reg] <= push0 ? data0 : data1;
        end
        if (push0 && push1) begin
            mem_reg[wptr_reg + PW'(1)] <= data1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rptr_reg];
    assign count     = count_reg;

`ifndef SYNTHESIS
    // Pushes always find room
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push0 || push1) |-> ((count_reg + n_push) <= CW'(DEPTH)))
        else $error("result queue overflow");
`endif

endmodule

### tb/tb_median_3x3_image_filter.sv
// Self-checking testbench for the streaming 3x3 median filter with replicated border.
`timescale 1ns / 1ps

module tb_median_3x3_image_filter;

    import mf3_pkg::*;

    localparam int MAXC          = MAX_COLS_DEF;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;     // margin for the pipeline to settle
    localparam int RANDOM_ITEMS  = 650;
    localparam int MAX_REPORTS   = 40;

    // Register indexes the block does not decode
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_kind_t;

    typedef enum logic {
        STEP_ITEM,
        STEP_REG
    } step_kind_t;

    typedef enum logic [1:0] {
        PIX_UNIFORM,
        PIX_NARROW,
        PIX_EXTREME
    } pix_mode_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BLOCK
    } rx_mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       last_item;
        logic       last_frame;
    } filt_result_t;

    typedef struct packed {
        step_kind_t                kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  data;
        req_kind_t                 req;
        logic [7:0]                pix;
        logic                      typed;
        filt_result_t              want;
    } dir_step_t;

    // DUT signals; those driven by the bench are known from time zero
    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic                      s_req_type    = 1'b0;
    logic [7:0]                s_pixel_value = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic [7:0]                m_filtered_value;
    logic [7:0]                m_running_min;
    logic [7:0]                m_running_max;
    logic                      m_last_of_item;
    logic                      m_last_of_frame;

    // Filter model state
    bit [7:0]    line_up  [0:MAXC-1];
    bit [7:0]    line_mid [0:MAXC-1];
    bit [7:0]    win      [0:8];     // index = column*3 + row, column 0 leftmost
    bit [11:0]   rows_reg;
    bit [10:0]   cols_reg;
    int unsigned row_pos, col_pos, drain_pos;
    bit [7:0]    lo_seen, hi_seen;

    filt_result_t pending_medians[$];

    int       err_count     = 0;
    int       cycle_count   = 0;
    int       counted_items = 0;
    int       burst_left    = 0;
    rx_mode_t rx_mode       = RX_OPEN;
    int       mode_left     = 0;
    int       pat_cnt       = 0;

    median_3x3_image_filter u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_pixel_value    (s_pixel_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value),
        .m_running_min    (m_running_min),
        .m_running_max    (m_running_max),
        .m_last_of_item   (m_last_of_item),
        .m_last_of_frame  (m_last_of_frame)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------

    function automatic int eff_rows();
        return (rows_reg == 0) ? 1 : int'(rows_reg);
    endfunction

    function automatic int eff_cols();
        if (cols_reg == 0) return 1;
        return (int'(cols_reg) > MAXC) ? MAXC : int'(cols_reg);
    endfunction

    function automatic void restart_frame_model();
        row_pos   = 0;
        col_pos   = 0;
        drain_pos = 0;
        lo_seen   = 8'hFF;
        hi_seen   = 8'h00;
    endfunction

    // Fifth smallest of nine values packed into one vector
    function automatic logic [7:0] median9(input logic [71:0] vals);
        logic [7:0] v [0:8];
        logic [7:0] t;
        int         i, j;
        for (i = 0; i < 9; i++) v[i] = vals[i*8 +: 8];
        for (i = 0; i < 8; i++) begin
            for (j = 0; j < 8 - i; j++) begin
                if (v[j] > v[j+1]) begin
                    t      = v[j];
                    v[j]   = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        return v[4];
    endfunction

    function automatic void post_median(input logic [7:0] v, input bit li, input bit lf);
        filt_result_t res;
        if (v < lo_seen) lo_seen = v;
        if (v > hi_seen) hi_seen = v;
        res.value      = v;
        res.lo         = lo_seen;
        res.hi         = hi_seen;
        res.last_item  = li;
        res.last_frame = lf;
        pending_medians.push_back(res);
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_ROW_COUNT: begin
                rows_reg = data[11:0];
                restart_frame_model();
            end
            CFG_COL_COUNT: begin
                cols_reg = data[10:0];
                restart_frame_model();
            end
            default: ;
        endcase
    endfunction

    // Advances the model by one transaction; returns 0 when the block ignores it
    function automatic bit compute_medians(input req_kind_t req, input logic [7:0] pix);
        int unsigned n_rows, n_cols, c, d, l, r;
        bit [7:0]    mid, top, tl, td, tr;
        bit          last_col;
        n_rows = eff_rows();
        n_cols = eff_cols();
        if (req == REQ_PIXEL) begin
            c = col_pos;
            if (row_pos >= n_rows || c >= n_cols) return 1'b0;
            mid         = line_mid[c];
            top         = (row_pos >= 2) ? line_up[c] : mid;
            line_up[c]  = mid;
            line_mid[c] = pix;
            // first column reloads the window, others shift it left
            if (c == 0) begin
                for (int k = 0; k < 3; k++) begin
                    win[k*3]   = top;
                    win[k*3+1] = mid;
                    win[k*3+2] = pix;
                end
            end else begin
                for (int k = 0; k < 6; k++) win[k] = win[k+3];
                win[6] = top;
                win[7] = mid;
                win[8] = pix;
            end
            if (row_pos >= 1) begin
                last_col = (c + 1 == n_cols);
                if (c >= 1)
                    post_median(median9({win[0], win[1], win[2], win[3], win[4],
                                         win[5], win[6], win[7], win[8]}),
                                !last_col, 1'b0);
                if (last_col)
                    post_median(median9({win[3], win[4], win[5], win[6], win[7],
                                         win[8], win[6], win[7], win[8]}),
                                1'b1, 1'b0);
            end
            col_pos = c + 1;
            if (col_pos >= n_cols) begin
                col_pos = 0;
                row_pos++;
            end
            return 1'b1;
        end
        // drain: bottom row, its lower neighbor replicated
        if (row_pos < n_rows) return 1'b0;
        d  = (drain_pos >= n_cols) ? n_cols - 1 : drain_pos;
        l  = (d == 0) ? 0 : d - 1;
        r  = (d + 1 < n_cols) ? d + 1 : d;
        tl = (n_rows >= 2) ? line_up[l] : line_mid[l];
        td = (n_rows >= 2) ? line_up[d] : line_mid[d];
        tr = (n_rows >= 2) ? line_up[r] : line_mid[r];
        last_col = (d + 1 == n_cols);
        post_median(median9({tl, line_mid[l], line_mid[l], td, line_mid[d], line_mid[d],
                             tr, line_mid[r], line_mid[r]}), 1'b1, last_col);
        drain_pos = d + 1;
        if (last_col) restart_frame_model();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------

    function automatic dir_step_t item_step(input req_kind_t req, input logic [7:0] pix);
        dir_step_t s;
        s       = '0;
        s.kind  = STEP_ITEM;
        s.req   = req;
        s.pix   = pix;
        return s;
    endfunction

    function automatic dir_step_t typed_step(input req_kind_t req, input logic [7:0] pix,
                                             input logic [7:0] v, input logic [7:0] lo,
                                             input logic [7:0] hi, input bit lf);
        dir_step_t s;
        s                 = item_step(req, pix);
        s.typed           = 1'b1;
        s.want.value      = v;
        s.want.lo         = lo;
        s.want.hi         = hi;
        s.want.last_item  = 1'b1;
        s.want.last_frame = lf;
        return s;
    endfunction

    function automatic dir_step_t reg_step(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] data);
        dir_step_t s;
        s      = '0;
        s.kind = STEP_REG;
        s.idx  = idx;
        s.data = data;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
    endtask

    // Drop valid, let every pending result drain, then let the pipeline settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_medians.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // One input transaction; typed expectation replaces the model's when given
    task automatic drive_item(input req_kind_t req, input logic [7:0] pix,
                              input bit use_typed, input filt_result_t typed);
        int gap;
        int n_before;
        bit did;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_pixel_value <= pix;
        do @(posedge aclk); while (!s_ready);
        n_before = pending_medians.size();
        did      = compute_medians(req, pix);
        if (use_typed) begin
            while (pending_medians.size() > n_before) void'(pending_medians.pop_back());
            pending_medians.push_back(typed);
        end
        if (did) counted_items++;
    endtask

    // Raster frame with random content and some noise; stops early at stop_at >= 0
    task automatic play_frame(input int n_rows, input int n_cols, input int stop_at);
        pix_mode_t  pm;
        int         px;
        int         total;
        int         base;
        logic [7:0] v;
        pm    = pix_mode_t'($urandom_range(0, 2));
        base  = $urandom_range(0, 252);
        total = n_rows * n_cols;
        for (px = 0; px < total; px++) begin
            if (px == stop_at) return;
            // early drain, ignored by the block
            if ($urandom_range(0, 24) == 0) drive_item(REQ_DRAIN, 8'($urandom), 1'b0, '0);
            case (pm)
                PIX_UNIFORM: v = 8'($urandom_range(0, 255));
                PIX_NARROW:  v = 8'(base + $urandom_range(0, 3));
                default:     v = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            endcase
            drive_item(REQ_PIXEL, v, 1'b0, '0);
        end
        // stray pixel after a complete frame
        if ($urandom_range(0, 3) == 0) drive_item(REQ_PIXEL, 8'($urandom), 1'b0, '0);
        for (px = 0; px < n_cols; px++) drive_item(REQ_DRAIN, 8'($urandom), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode   <= rx_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= ($urandom_range(0, 2) != 0);
            RX_PERIODIC: m_ready <= ((pat_cnt % 8) < 5);
            default:     m_ready <= ((pat_cnt % 24) >= 18);
        endcase
        pat_cnt <= pat_cnt + 1;
    end

    always @(posedge aclk) begin : result_check
        filt_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_medians.size() == 0) begin
                report_mismatch("unexpected result, value", int'(m_filtered_value), 0);
            end else begin
                want = pending_medians.pop_front();
                if (m_filtered_value != want.value)
                    report_mismatch("filtered_value", int'(m_filtered_value),
                                    int'(want.value));
                if (m_running_min != want.lo)
                    report_mismatch("running_min", int'(m_running_min), int'(want.lo));
                if (m_running_max != want.hi)
                    report_mismatch("running_max", int'(m_running_max), int'(want.hi));
                if (m_last_of_item != want.last_item)
                    report_mismatch("last_of_item", int'(m_last_of_item),
                                    int'(want.last_item));
                if (m_last_of_frame != want.last_frame)
                    report_mismatch("last_of_frame", int'(m_last_of_frame),
                                    int'(want.last_frame));
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        dir_step_t steps[$];
        int        frame_no;
        int        stop_at;
        int        total;
        bit        need_cfg;

        // model after reset
        for (int i = 0; i < MAXC; i++) begin
            line_up[i]  = '0;
            line_mid[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        rows_reg = 12'd1;
        cols_reg = 11'd1;
        restart_frame_model();

        // directed: single pixel frames, ignored transactions, register corners
        steps.push_back(item_step(REQ_DRAIN, 8'h00));                  // drain too early
        steps.push_back(item_step(REQ_PIXEL, 8'hFF));
        steps.push_back(typed_step(REQ_DRAIN, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        steps.push_back(item_step(REQ_PIXEL, 8'h00));
        steps.push_back(typed_step(REQ_DRAIN, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));
        steps.push_back(item_step(REQ_PIXEL, 8'h12));
        steps.push_back(item_step(REQ_PIXEL, 8'h34));                  // frame full, ignored
        steps.push_back(typed_step(REQ_DRAIN, 8'h5A, 8'h12, 8'h12, 8'h12, 1'b1));
        steps.push_back(reg_step(CFG_ROW_COUNT, 12'd0));               // zero rows -> 1
        steps.push_back(reg_step(CFG_COL_COUNT, 12'd0));               // zero cols -> 1
        steps.push_back(reg_step(CFG_SPARE_A, 12'hFFF));
        steps.push_back(reg_step(CFG_SPARE_B, 12'hAAA));
        steps.push_back(item_step(REQ_PIXEL, 8'h77));
        steps.push_back(typed_step(REQ_DRAIN, 8'h00, 8'h77, 8'h77, 8'h77, 1'b1));
        // 2x2 frame
        steps.push_back(reg_step(CFG_ROW_COUNT, 12'd2));
        steps.push_back(reg_step(CFG_COL_COUNT, 12'd2));
        steps.push_back(item_step(REQ_PIXEL, 8'd10));
        steps.push_back(item_step(REQ_DRAIN, 8'h00));
        steps.push_back(item_step(REQ_PIXEL, 8'd200));
        steps.push_back(item_step(REQ_PIXEL, 8'd30));
        steps.push_back(item_step(REQ_PIXEL, 8'd255));
        steps.push_back(item_step(REQ_PIXEL, 8'd99));
        steps.push_back(item_step(REQ_DRAIN, 8'h00));
        steps.push_back(item_step(REQ_DRAIN, 8'hFF));
        // single column, three rows
        steps.push_back(reg_step(CFG_ROW_COUNT, 12'd3));
        steps.push_back(reg_step(CFG_COL_COUNT, 12'd1));
        steps.push_back(item_step(REQ_PIXEL, 8'd0));
        steps.push_back(item_step(REQ_PIXEL, 8'd255));
        steps.push_back(item_step(REQ_PIXEL, 8'd128));
        steps.push_back(item_step(REQ_DRAIN, 8'h00));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (steps[i]) begin
            if (steps[i].kind == STEP_REG) begin
                wait_idle();
                write_reg(steps[i].idx, steps[i].data);
            end else begin
                drive_item(steps[i].req, steps[i].pix, steps[i].typed, steps[i].want);
            end
        end

        // random frames; the first two exercise the largest register settings
        frame_no = 0;
        need_cfg = 1'b1;
        while (counted_items < RANDOM_ITEMS) begin
            wait_idle();
            stop_at = -1;
            if (frame_no == 0) begin
                write_reg(CFG_ROW_COUNT, 12'd2);
                write_reg(CFG_COL_COUNT, 12'hFFF);    // clamps to full line width
                stop_at = 40;
            end else if (frame_no == 1) begin
                write_reg(CFG_ROW_COUNT, 12'hFFF);
                write_reg(CFG_COL_COUNT, 12'd1);
                stop_at = 60;
            end else begin
                if (need_cfg || $urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 19) == 0)
                        write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                  12'($urandom_range(0, 4095)));
                    if (need_cfg || $urandom_range(0, 2) != 0)
                        write_reg(CFG_ROW_COUNT, ($urandom_range(0, 9) == 0) ?
                                  12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 6)));
                    write_reg(CFG_COL_COUNT, ($urandom_range(0, 14) == 0) ?
                              12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 9)));
                end
                total = eff_rows() * eff_cols();
                if (total > 300)
                    stop_at = $urandom_range(1, 80);
                else if ($urandom_range(0, 9) == 0)
                    stop_at = $urandom_range(0, total - 1);
            end
            need_cfg = (stop_at >= 0);
            play_frame(eff_rows(), eff_cols(), stop_at);
            frame_no++;
        end

        wait_idle();
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### median_3x3_image_filter.f
hdl/mf3_pkg.sv
hdl/mf3_ram.sv
hdl/mf3_ctrl.sv
hdl/mf3_window.sv
hdl/mf3_median.sv
hdl/mf3_fifo.sv
hdl/median_3x3_image_filter.sv
tb/tb_median_3x3_image_filter.sv
